FILE: rtl/adc_frame_crc_checker_defines.svh
// ----------------------------------------------------------------------------
// adc frame crc checker assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef ADC_FRAME_CRC_CHECKER_DEFINES_SVH
`define ADC_FRAME_CRC_CHECKER_DEFINES_SVH

// same-cycle implication
`define AFCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("afcc check failed");

// next-cycle implication
`define AFCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("afcc check failed");

`endif

FILE: rtl/afcc_pkg.sv
// ----------------------------------------------------------------------------
// afcc_pkg
// types, constants and the crc byte update shared by the frame checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afcc_pkg;

  localparam int POS_W       = 4;
  localparam int CRC_BYTES   = 9;
  localparam int LAST_POS    = 11;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [15:0] CRC_POLY_RESET = 16'h1021;
  localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;

  typedef enum logic {
    REG_CRC_POLYNOMIAL = 1'b0,
    REG_CRC_SEED       = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_FOLD  = 2'd0,
    OP_RXCRC = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } byte_item_t;

  typedef struct packed {
    logic        [23:0] status_word;
    logic signed [23:0] primary_sample;
    logic signed [23:0] secondary_sample;
    logic               crc_good;
    logic        [15:0] computed_crc;
  } frame_result_t;

  typedef struct packed {
    op_t        op;
    logic       frame_first;
    logic [1:0] word_sel;
    logic [7:0] data_byte;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] crc,
                                           input logic [7:0]  data,
                                           input logic [15:0] poly);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = data[i] ^ c[15];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  function automatic logic [1:0] word_of(input logic [POS_W-1:0] pos);
    logic [1:0] w;
    case (pos) inside
      [4'd0:4'd2]: w = 2'd0;
      [4'd3:4'd5]: w = 2'd1;
      [4'd6:4'd8]: w = 2'd2;
      default:     w = 2'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/afcc_front.sv
// ----------------------------------------------------------------------------
// afcc_front
// byte intake: tracks the frame position and classifies each byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afcc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  afcc_pkg::byte_item_t byte_item,
  input  afcc_pkg::q_stat_t   q_stat,
  output logic                push,
  output afcc_pkg::entry_t    entry
);
  import afcc_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] pos_cur;

  assign byte_ready = !q_stat.full;
  assign push       = byte_valid && !q_stat.full;

  always_comb begin
    if (byte_item.frame_start || (pos > POS_W'(LAST_POS))) begin
      pos_cur = '0;
    end else begin
      pos_cur = pos;
    end
    if (pos_cur == POS_W'(LAST_POS)) begin
      pos_next = '0;
    end else begin
      pos_next = pos_cur + POS_W'(1);
    end

    entry.frame_first = (pos_cur == '0);
    entry.word_sel    = word_of(pos_cur);
    entry.data_byte   = byte_item.data_byte;
    if (pos_cur < POS_W'(CRC_BYTES)) begin
      entry.op = OP_FOLD;
    end else if (pos_cur < POS_W'(LAST_POS)) begin
      entry.op = OP_RXCRC;
    end else begin
      entry.op = OP_CLOSE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      pos <= pos_next;
    end
  end

endmodule

FILE: rtl/afcc_queue.sv
// ----------------------------------------------------------------------------
// afcc_queue
// short fifo of classified items between intake and execution
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afcc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  afcc_pkg::entry_t  entry,
  input  logic              pop,
  output afcc_pkg::entry_t  head,
  output afcc_pkg::q_stat_t q_stat
);
  import afcc_pkg::*;

  entry_t              slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/afcc_back.sv
// ----------------------------------------------------------------------------
// afcc_back
// execution: crc update, word assembly, verdict and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module afcc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [15:0]            crc_polynomial,
  input  logic [15:0]            crc_seed,
  input  afcc_pkg::entry_t       head,
  input  afcc_pkg::q_stat_t      q_stat,
  output logic                   pop,
  output logic                   frame_valid,
  input  logic                   frame_ready,
  output afcc_pkg::frame_result_t frame_result
);
  import afcc_pkg::*;

  logic [15:0] crc_reg;
  logic [15:0] crc_base;
  logic [23:0] words [3];
  logic [15:0] rx_crc;
  logic [23:0] kept_primary;
  logic [23:0] kept_secondary;
  logic        good;
  logic        do_close;

  assign pop = !q_stat.empty &&
               ((head.op != OP_CLOSE) || !frame_valid || frame_ready);
  assign do_close = pop && (head.op == OP_CLOSE);
  assign crc_base = head.frame_first ? crc_seed : crc_reg;
  assign good     = (crc_reg == rx_crc);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg        <= CRC_SEED_RESET;
      kept_primary   <= '0;
      kept_secondary <= '0;
    end else if (pop) begin
      unique case (head.op)
        OP_FOLD: begin
          crc_reg <= crc_fold(crc_base, head.data_byte, crc_polynomial);
        end
        OP_RXCRC: begin
        end
        OP_CLOSE: begin
          if (good) begin
            kept_primary   <= words[1];
            kept_secondary <= words[2];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      unique case (head.op)
        OP_FOLD: begin
          case (head.word_sel)
            2'd0:    words[0] <= {words[0][15:0], head.data_byte};
            2'd1:    words[1] <= {words[1][15:0], head.data_byte};
            2'd2:    words[2] <= {words[2][15:0], head.data_byte};
            default: words[0] <= {words[0][15:0], head.data_byte};
          endcase
        end
        OP_RXCRC: begin
          rx_crc <= {rx_crc[7:0], head.data_byte};
        end
        OP_CLOSE: begin
          frame_result.status_word      <= words[0];
          frame_result.primary_sample   <= good ? words[1] : kept_primary;
          frame_result.secondary_sample <= good ? words[2] : kept_secondary;
          frame_result.crc_good         <= good;
          frame_result.computed_crc     <= crc_reg;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (do_close) begin
      frame_valid <= 1'b1;
    end else if (frame_ready) begin
      frame_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/adc_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// adc_frame_crc_checker
// result: a frame's twelfth byte is written into a queue slot; its close is
//   popped into the result register, held while a prior result is unaccepted
// throughput: one byte per cycle unless the queue fills while results wait
// reset: synchronous; clears frame position, queue, result valid and kept
//   samples, loads polynomial 0x1021 and seed 0xffff; no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "adc_frame_crc_checker_defines.svh"

module adc_frame_crc_checker (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  afcc_pkg::cfg_reg_t      cfg_index,
  input  logic [15:0]             cfg_data,
  input  logic                    byte_valid,
  output logic                    byte_ready,
  input  afcc_pkg::byte_item_t    byte_item,
  output logic                    frame_valid,
  input  logic                    frame_ready,
  output afcc_pkg::frame_result_t frame_result
);
  import afcc_pkg::*;

  logic [15:0] crc_polynomial;
  logic [15:0] crc_seed;
  logic        push;
  logic        pop;
  entry_t      entry;
  entry_t      head;
  q_stat_t     q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= CRC_POLY_RESET;
      crc_seed       <= CRC_SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CRC_POLYNOMIAL: crc_polynomial <= cfg_data;
        REG_CRC_SEED:       crc_seed       <= cfg_data;
      endcase
    end
  end

  afcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_stat     (q_stat),
    .push       (push),
    .entry      (entry)
  );

  afcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .entry  (entry),
    .pop    (pop),
    .head   (head),
    .q_stat (q_stat)
  );

  afcc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .crc_polynomial (crc_polynomial),
    .crc_seed       (crc_seed),
    .head           (head),
    .q_stat         (q_stat),
    .pop            (pop),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_result   (frame_result)
  );

  `AFCC_ASSERT_SAME(a_full_blocks_intake, q_stat.full, !byte_ready)
  `AFCC_ASSERT_SAME(a_no_pop_when_empty, q_stat.empty, !pop)
  `AFCC_ASSERT_NEXT(a_close_gives_result, pop && (head.op == OP_CLOSE), frame_valid)

endmodule
